### src/fpd_pkg.sv
// Package for the framed packet deframer with checksum check.
// Holds frame constants, the status codes and the result record.
// No dependencies.
package fpd_pkg;

  // Frame delimiters and layout
  localparam logic [7:0] START_BYTE    = 8'h7B;
  localparam logic [7:0] END_BYTE      = 8'h7D;
  localparam int unsigned POS_W        = 9;
  localparam logic [POS_W-1:0] HEADER_LEN = 9'd16;

  // Configuration register map
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;
  localparam logic REG_MAX_LEN         = 1'b0;
  localparam logic [7:0] MAX_LEN_RESET = 8'd240;

  typedef enum logic [1:0] {
    FS_OK      = 2'd0,
    FS_LEN_ERR = 2'd1,
    FS_END_ERR = 2'd2,
    FS_SUM_ERR = 2'd3
  } fpd_status_e;

  typedef struct packed {
    fpd_status_e frame_status;
    logic [15:0] frame_id;
    logic [31:0] sequence_number;
    logic [31:0] time_stamp;
    logic [15:0] payload_length;
  } fpd_result_t;

endpackage

### src/fpd_if.sv
// Handshake channel interfaces of the deframer: byte stream in, frame status out.
// Each carries valid, ready and the payload. No dependencies.
interface fpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fpd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [15:0] frame_id;
  logic [31:0] sequence_number;
  logic [31:0] time_stamp;
  logic [15:0] payload_length;

  modport source (output valid, output frame_status, output frame_id,
                  output sequence_number, output time_stamp,
                  output payload_length, input ready);
  modport sink (input valid, input frame_status, input frame_id,
                input sequence_number, input time_stamp,
                input payload_length, output ready);
endinterface

### src/fpd_cfg.sv
// APB-style configuration register block: holds the maximum payload length.
// Depends on fpd_pkg.
module fpd_cfg import fpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [7:0]         max_len_o
);

  logic [7:0] max_len_q, max_len_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_MAX_LEN);

  // Capture a write request to the length limit
  always_comb begin
    max_len_d = max_len_q;
    if (wr_en) begin
      max_len_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  // Read back; unmapped addresses return zero
  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_MAX_LEN) begin
      prdata = {{(PDATA_W-8){1'b0}}, max_len_q};
    end
  end

  assign max_len_o = max_len_q;

endmodule

### src/fpd_parse.sv
// Frame parser: tracks byte position, gathers header fields, sums the checksum
// and produces one status record per finished or aborted frame. Depends on fpd_pkg.
module fpd_parse import fpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  max_len_i,
  output logic        res_valid_o,
  output fpd_result_t res_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      len_q, len_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       rsum_q, rsum_d;
  logic [31:0]      seq_q, seq_d;
  logic [31:0]      stamp_q, stamp_d;
  logic [15:0]      ident_q, ident_d;
  logic [POS_W-1:0] sum_pos;
  logic [15:0]      new_len;
  logic             is_start;
  fpd_status_e      status;

  // Position of the checksum byte; the limit keeps the length below 256
  assign sum_pos  = HEADER_LEN + {1'b0, len_q[7:0]};
  assign new_len  = {rx_byte_i, len_q[7:0]};
  assign is_start = (rx_byte_i == START_BYTE);

  // Advance the frame state for one accepted byte
  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    sum_d       = sum_q;
    rsum_d      = rsum_q;
    seq_d       = seq_q;
    stamp_d     = stamp_q;
    ident_d     = ident_q;
    res_valid_o = 1'b0;
    status      = FS_OK;
    if (accept_i) begin
      if (pos_q == '0) begin
        // Hunt for the start byte
        if (is_start) begin
          pos_d = {{(POS_W-1){1'b0}}, 1'b1};
          sum_d = '0;
        end
      end else if (pos_q < HEADER_LEN) begin
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + 1'b1;
        case (pos_q[3:0])
          4'd2:  seq_d[7:0]     = rx_byte_i;
          4'd3:  seq_d[15:8]    = rx_byte_i;
          4'd4:  seq_d[23:16]   = rx_byte_i;
          4'd5:  seq_d[31:24]   = rx_byte_i;
          4'd8:  stamp_d[7:0]   = rx_byte_i;
          4'd9:  stamp_d[15:8]  = rx_byte_i;
          4'd10: stamp_d[23:16] = rx_byte_i;
          4'd11: stamp_d[31:24] = rx_byte_i;
          4'd12: ident_d[7:0]   = rx_byte_i;
          4'd13: ident_d[15:8]  = rx_byte_i;
          4'd14: len_d[7:0]     = rx_byte_i;
          4'd15: begin
            len_d = new_len;
            // Abort an oversized frame; the same byte may open the next one
            if (new_len > {8'd0, max_len_i}) begin
              res_valid_o = 1'b1;
              status      = FS_LEN_ERR;
              if (is_start) begin
                pos_d = {{(POS_W-1){1'b0}}, 1'b1};
                sum_d = '0;
              end else begin
                pos_d = '0;
              end
            end
          end
          default: ;
        endcase
      end else if (pos_q < sum_pos) begin
        // Payload byte
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + 1'b1;
      end else if (pos_q == sum_pos) begin
        // Checksum byte
        rsum_d = rx_byte_i;
        pos_d  = pos_q + 1'b1;
      end else begin
        // End byte: report and go back to hunting
        pos_d       = '0;
        res_valid_o = 1'b1;
        if (rx_byte_i != END_BYTE) begin
          status = FS_END_ERR;
        end else if (sum_q != rsum_q) begin
          status = FS_SUM_ERR;
        end else begin
          status = FS_OK;
        end
      end
    end
  end

  always_comb begin
    res_o.frame_status    = status;
    res_o.frame_id        = ident_d;
    res_o.sequence_number = seq_d;
    res_o.time_stamp      = stamp_d;
    res_o.payload_length  = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      rsum_q  <= '0;
      seq_q   <= '0;
      stamp_q <= '0;
      ident_q <= '0;
    end else begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      rsum_q  <= rsum_d;
      seq_q   <= seq_d;
      stamp_q <= stamp_d;
      ident_q <= ident_d;
    end
  end

endmodule

### src/fpd_out_reg.sv
// Result output register: holds one status record until the receiver takes it.
// Depends on fpd_pkg and fpd_if.
module fpd_out_reg import fpd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  fpd_result_t   res_i,
  output logic          free_o,
  fpd_result_if.source  res_o
);

  logic        valid_q, valid_d;
  fpd_result_t data_q, data_d;

  // Space for a new record when empty or when the held one leaves now
  assign free_o = !valid_q || res_o.ready;

  // Load a new record, or drop the held one once taken
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = res_i;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign res_o.valid           = valid_q;
  assign res_o.frame_status    = data_q.frame_status;
  assign res_o.frame_id        = data_q.frame_id;
  assign res_o.sequence_number = data_q.sequence_number;
  assign res_o.time_stamp      = data_q.time_stamp;
  assign res_o.payload_length  = data_q.payload_length;

endmodule

### src/framed_packet_deframer_sum_check.sv
// Framed packet deframer with 8-bit additive checksum check.
//
// rx_i carries one received byte per request. The block hunts for '{', collects
// a 16-byte header (sequence number, timestamp, identifier, payload length),
// skips the payload, then checks the checksum byte and the closing '}'.
// res_o carries one status request per frame: ok, length too large, end marker
// missing or checksum mismatch, together with the header fields.
// The APB port holds max_payload_len at address 0 (reset value 240); write it
// only while no frame is in flight.
// Throughput: one byte per cycle unless rx_i stalls, set by the position update
// and 8-bit add in the parser. Latency: a result is valid on res_o in the cycle
// after the byte that closes (or aborts) the frame is accepted.
// A single output register sits between parser and receiver: rx_i stays ready
// while that register is empty or being taken, and stalls only when a result
// waits and res_o.ready is low.
// Reset clears the parser to the hunting state and empties the output register.
// Depends on fpd_pkg, fpd_if, fpd_cfg, fpd_parse and fpd_out_reg.
module framed_packet_deframer_sum_check import fpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  fpd_byte_if.sink           rx_i,
  fpd_result_if.source       res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [7:0]  max_len_val;
  logic        rx_accept;
  logic        out_free;
  logic        res_valid;
  fpd_result_t res_rec;

  fpd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len_val)
  );

  // Take a byte whenever the output register has room
  assign rx_i.ready = out_free;
  assign rx_accept  = rx_i.valid && out_free;

  fpd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (rx_accept),
    .rx_byte_i   (rx_i.rx_byte),
    .max_len_i   (max_len_val),
    .res_valid_o (res_valid),
    .res_o       (res_rec)
  );

  fpd_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_valid),
    .res_i  (res_rec),
    .free_o (out_free),
    .res_o  (res_o)
  );

`ifndef SYNTH
  // A result is only produced by an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> rx_accept)
    else $error("result produced without an accepted byte");

  // A produced result shows up on the output in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> res_o.valid)
    else $error("result lost before the output register");

  // A length error always reports a length above the configured limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.frame_status == FS_LEN_ERR)) |->
      (res_o.payload_length > {8'd0, max_len_val}))
    else $error("length error reported for an acceptable length");

  // Input is never stalled while the output register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_o.valid |-> rx_i.ready)
    else $error("input stalled with an empty output register");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for framed_packet_deframer_sum_check: directed and random
// byte streams, scoreboard of frame status requests. Needs fpd_pkg, fpd_if and the RTL.
module testbench;
  import fpd_pkg::*;

  localparam logic [PADDR_W-1:0] MAX_LEN_ADDR = PADDR_W'(4 * REG_MAX_LEN);
  localparam logic [PADDR_W-1:0] SPARE_ADDR   = PADDR_W'(4 * (REG_MAX_LEN + 1));
  localparam int FULL_FRAME = 1 << 20;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  fpd_byte_if   rx_if ();
  fpd_result_if res_if ();

  framed_packet_deframer_sum_check DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Parser mirror: position, header fields, sums and the length limit
  logic [8:0]  frame_pos = '0;
  logic [15:0] len_q     = '0;
  logic [7:0]  run_sum   = '0;
  logic [7:0]  got_sum   = '0;
  logic [31:0] seq_q     = '0;
  logic [31:0] stamp_q   = '0;
  logic [15:0] ident_q   = '0;
  logic [7:0]  max_len_q = MAX_LEN_RESET;

  fpd_result_t expected_status[$];
  logic [7:0]  frame_bytes[$];

  int src_gap_pct       = 0;
  int sink_stall_pct    = 0;
  int mismatches        = 0;
  int bytes_sent        = 0;
  int results_predicted = 0;
  int results_checked   = 0;
  int reg_writes        = 0;
  int status_seen[4]    = '{0, 0, 0, 0};

  // Clock and drive every input to a known value
  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = 8'h00;
    res_if.ready   = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  // Receiver: stall at random at the rate of the current phase
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Record the status request the block owes for the frame just closed
  function automatic void queue_status(input fpd_status_e st);
    fpd_result_t r;
    r.frame_status    = st;
    r.frame_id        = ident_q;
    r.sequence_number = seq_q;
    r.time_stamp      = stamp_q;
    r.payload_length  = len_q;
    expected_status.push_back(r);
    results_predicted++;
  endfunction

  // Advance the parser mirror by one accepted byte
  task automatic deframe_step(input logic [7:0] value);
    if (frame_pos == 0) begin
      if (value == START_BYTE) begin
        frame_pos = 9'd1;
        run_sum   = 8'h00;
      end
    end else if (frame_pos < HEADER_LEN) begin
      run_sum += value;
      if (frame_pos >= 2 && frame_pos <= 5) seq_q[8*(frame_pos-2) +: 8] = value;
      else if (frame_pos >= 8 && frame_pos <= 11) stamp_q[8*(frame_pos-8) +: 8] = value;
      else if (frame_pos == 12) ident_q[7:0] = value;
      else if (frame_pos == 13) ident_q[15:8] = value;
      else if (frame_pos == 14) len_q[7:0] = value;
      else if (frame_pos == 15) len_q[15:8] = value;
      // An oversized length aborts; the same byte may open the next frame
      if (frame_pos == 15 && len_q > {8'h00, max_len_q}) begin
        queue_status(FS_LEN_ERR);
        frame_pos = (value == START_BYTE) ? 9'd1 : 9'd0;
        run_sum   = 8'h00;
      end else begin
        frame_pos++;
      end
    end else if (frame_pos < HEADER_LEN + len_q) begin
      run_sum += value;
      frame_pos++;
    end else if (frame_pos == HEADER_LEN + len_q) begin
      got_sum = value;
      frame_pos++;
    end else begin
      frame_pos = 9'd0;
      if (value != END_BYTE) queue_status(FS_END_ERR);
      else if (run_sum != got_sum) queue_status(FS_SUM_ERR);
      else queue_status(FS_OK);
    end
  endtask

  // Compare each status request with the oldest expectation
  always @(posedge clk_i) begin : check_results
    fpd_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_status.size() == 0) begin
        $display("%0t ns: unexpected status request: expected none, actual status %0d id 0x%0h",
                 $time, res_if.frame_status, res_if.frame_id);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        check_field("frame_status", 32'(want.frame_status), 32'(res_if.frame_status));
        check_field("frame_id", 32'(want.frame_id), 32'(res_if.frame_id));
        check_field("sequence_number", want.sequence_number, res_if.sequence_number);
        check_field("time_stamp", want.time_stamp, res_if.time_stamp);
        check_field("payload_length", 32'(want.payload_length), 32'(res_if.payload_length));
        results_checked++;
        status_seen[res_if.frame_status]++;
      end
    end
  end

  // Offer one byte after a random gap and hold it until the request is taken
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < src_gap_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= value;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_sent++;
    deframe_step(value);
  endtask

  // Build a frame and send its first keep bytes; skip the start byte if
  // the parser already opened the frame on an aborted header
  task automatic deliver_frame(input logic [31:0] seq, input logic [31:0] stamp,
                               input logic [15:0] ident, input logic [15:0] len,
                               input logic [7:0] sum_skew, input logic [7:0] end_mark,
                               input int keep);
    logic [7:0] hdr[16];
    logic [7:0] sum;
    logic [7:0] pay;
    int         first;
    hdr[0] = START_BYTE;
    hdr[1] = 8'($urandom);
    hdr[6] = 8'($urandom);
    hdr[7] = 8'($urandom);
    for (int i = 0; i < 4; i++) begin
      hdr[2+i] = seq[8*i +: 8];
      hdr[8+i] = stamp[8*i +: 8];
    end
    hdr[12] = ident[7:0];
    hdr[13] = ident[15:8];
    hdr[14] = len[7:0];
    hdr[15] = len[15:8];
    frame_bytes.delete();
    sum = 8'h00;
    for (int i = 0; i < 16; i++) begin
      frame_bytes.push_back(hdr[i]);
      if (i != 0) sum += hdr[i];
    end
    // An oversized length ends the frame with the header
    if (len <= {8'h00, max_len_q}) begin
      for (int i = 0; i < len; i++) begin
        pay = 8'($urandom);
        frame_bytes.push_back(pay);
        sum += pay;
      end
      frame_bytes.push_back(sum + sum_skew);
      frame_bytes.push_back(end_mark);
    end
    first = (frame_pos == 1) ? 1 : 0;
    for (int i = first; i < keep && i < frame_bytes.size(); i++) send_byte(frame_bytes[i]);
  endtask

  // Close any open frame with filler, drop valid, wait for every result
  task automatic settle_block();
    while (frame_pos != 0) send_byte(8'h00);
    rx_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_status.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write the length limit while idle and read it back
  task automatic program_max_len(input logic [7:0] value);
    logic [PDATA_W-1:0] rd;
    settle_block();
    apb_write(MAX_LEN_ADDR, PDATA_W'(value));
    max_len_q = value;
    apb_read(MAX_LEN_ADDR, rd);
    check_field("max_payload_len", 32'(max_len_q), 32'(rd));
  endtask

  // Hunting noise and short good frames;
  // hold the sender between frames until all results are back
  task automatic test_good_frames();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(END_BYTE);
    send_byte(8'h80);
    deliver_frame(32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'd0, 8'h00, END_BYTE, FULL_FRAME);
    settle_block();
    deliver_frame(32'h0, 32'hFFFF_FFFF, 16'h0, 16'd1, 8'h00, END_BYTE, FULL_FRAME);
    settle_block();
    deliver_frame($urandom, $urandom, 16'($urandom), 16'd7, 8'h00, END_BYTE,
                  FULL_FRAME);
    settle_block();
  endtask

  // Oversized lengths, one whose top byte restarts a frame, then a good frame
  task automatic test_length_errors();
    deliver_frame($urandom, $urandom, 16'($urandom), 16'(MAX_LEN_RESET) + 16'd1, 8'h00,
                  END_BYTE, FULL_FRAME);
    deliver_frame($urandom, $urandom, 16'($urandom), {START_BYTE, 8'h05}, 8'h00, END_BYTE,
                  FULL_FRAME);
    deliver_frame($urandom, $urandom, 16'($urandom), 16'd3, 8'h00, END_BYTE, FULL_FRAME);
    deliver_frame($urandom, $urandom, 16'($urandom), 16'hFFFF, 8'h00, END_BYTE, FULL_FRAME);
  endtask

  // Bad end marker, bad checksum, and both together
  task automatic test_trailer_errors();
    deliver_frame($urandom, $urandom, 16'($urandom), 16'd2, 8'h00, 8'h00, FULL_FRAME);
    deliver_frame($urandom, $urandom, 16'($urandom), 16'd0, 8'h01, END_BYTE, FULL_FRAME);
    deliver_frame($urandom, $urandom, 16'($urandom), 16'd4, 8'h80, START_BYTE, FULL_FRAME);
  endtask

  // Limit at both extremes, and a write to an unmapped address
  task automatic test_limit_extremes();
    logic [PDATA_W-1:0] rd;
    program_max_len(8'd0);
    deliver_frame($urandom, $urandom, 16'($urandom), 16'd0, 8'h00, END_BYTE, FULL_FRAME);
    deliver_frame($urandom, $urandom, 16'($urandom), 16'd1, 8'h00, END_BYTE, FULL_FRAME);
    program_max_len(8'd255);
    deliver_frame($urandom, $urandom, 16'($urandom), 16'd255, 8'h00, END_BYTE, FULL_FRAME);
    deliver_frame($urandom, $urandom, 16'($urandom), 16'd256, 8'h00, END_BYTE, FULL_FRAME);
    settle_block();
    apb_write(SPARE_ADDR, '0);
    apb_read(MAX_LEN_ADDR, rd);
    check_field("max_payload_len", 32'(max_len_q), 32'(rd));
    deliver_frame($urandom, $urandom, 16'($urandom), 16'd9, 8'h00, END_BYTE, FULL_FRAME);
  endtask

  // Mostly well-formed frames with random content, some with trailer errors,
  // some oversized, some cut short, some plain noise
  task automatic test_random_traffic(input logic [7:0] max_len, input int gap_pct,
                                     input int stall_pct, input int min_bytes,
                                     input int min_results);
    int          bytes_at_start;
    int          results_at_start;
    int          pick;
    int          len_cap;
    logic [15:0] len;
    program_max_len(max_len);
    src_gap_pct      = gap_pct;
    sink_stall_pct   = stall_pct;
    bytes_at_start   = bytes_sent;
    results_at_start = results_predicted;
    len_cap          = (max_len_q < 12) ? max_len_q : 12;
    while (bytes_sent - bytes_at_start < min_bytes ||
           results_predicted - results_at_start < min_results) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(9) == 0) ? 16'($urandom_range(max_len_q))
                                       : 16'($urandom_range(len_cap));
        deliver_frame($urandom, $urandom, 16'($urandom), len,
                      ($urandom_range(7) == 0) ? 8'($urandom_range(255, 1)) : 8'h00,
                      ($urandom_range(7) == 0) ? 8'($urandom) : END_BYTE, FULL_FRAME);
      end else if (pick < 82) begin
        len = ($urandom_range(3) == 0) ? {START_BYTE, 8'($urandom)}
                                       : 16'($urandom_range(65535, max_len_q + 1));
        deliver_frame($urandom, $urandom, 16'($urandom), len, 8'h00, END_BYTE, FULL_FRAME);
      end else if (pick < 92) begin
        len = 16'($urandom_range(len_cap));
        deliver_frame($urandom, $urandom, 16'($urandom), len, 8'h00, END_BYTE,
                      $urandom_range(16 + len, 1));
      end else begin
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
      end
    end
  endtask

  // Main sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_good_frames();
    test_length_errors();
    test_trailer_errors();
    test_limit_extremes();
    test_random_traffic(8'd200, 0, 0, 60, 3);
    test_random_traffic(8'd0, 50, 0, 60, 3);
    test_random_traffic(8'd255, 0, 50, 60, 3);
    test_random_traffic(8'($urandom_range(254, 1)), 15, 15, 60, 3);
    settle_block();
    $display("Sent %0d bytes, %0d register writes; checked %0d status requests",
             bytes_sent, reg_writes, results_checked);
    $display("Status mix: %0d ok, %0d length, %0d end marker, %0d checksum",
             status_seen[FS_OK], status_seen[FS_LEN_ERR], status_seen[FS_END_ERR],
             status_seen[FS_SUM_ERR]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("%0t ns: run did not finish, %0d results still owed", $time,
             expected_status.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
